// ===== sv/bvde_pkg.sv =====
// ----------------------------------------------------------------------------
// bvde_pkg
// Shared widths, constants and types for the button vector debounce block.
// ----------------------------------------------------------------------------
package bvde_pkg;

	localparam int NUM_BUTTONS = 8;
	localparam int VEC_W       = 8;
	localparam int TIME_W      = 32;
	localparam int DEB_W       = 16;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(5);

	// buttons at or above NUM_BUTTONS are ignored
	localparam logic [VEC_W-1:0] BTN_MASK =
		(NUM_BUTTONS >= VEC_W) ? {VEC_W{1'b1}} : VEC_W'((1 << NUM_BUTTONS) - 1);

	typedef struct packed {
		logic [VEC_W-1:0]  stable_vector;
		logic [VEC_W-1:0]  last_raw;
		logic [TIME_W-1:0] last_change_time;
		logic [TIME_W-1:0] press_start_time;
		logic [TIME_W-1:0] press_finish_time;
	} bvde_state_t;

	typedef struct packed {
		logic [VEC_W-1:0]  stable_buttons;
		logic [VEC_W-1:0]  pressed_mask;
		logic [VEC_W-1:0]  released_mask;
		logic              any_pressed;
		logic              any_released;
		logic [TIME_W-1:0] held_ms;
	} bvde_result_t;

	typedef struct packed {
		logic [VEC_W-1:0]  raw_buttons;
		logic              read_failed;
		logic [TIME_W-1:0] now_ms;
	} bvde_sample_t;

endpackage

// ===== sv/bvde_eval.sv =====
// ----------------------------------------------------------------------------
// bvde_eval
// Combinational debounce step: next state and result for one sample.
// ----------------------------------------------------------------------------
module bvde_eval
	import bvde_pkg::*;
(
	input  bvde_sample_t      smp,
	input  logic [DEB_W-1:0]  debounce_ms,
	input  bvde_state_t       cur,
	output bvde_state_t       nxt,
	output bvde_result_t      res
);

	logic [VEC_W-1:0]  sample;
	logic [TIME_W-1:0] elapsed;
	logic              upd;
	logic [VEC_W-1:0]  pressed;
	logic [VEC_W-1:0]  released;

	always_comb begin
		sample = smp.read_failed ? '0 : (smp.raw_buttons & BTN_MASK);
		nxt = cur;

		if (sample != cur.last_raw) begin
			nxt.last_raw         = sample;
			nxt.last_change_time = smp.now_ms;
		end

		elapsed  = smp.now_ms - nxt.last_change_time;
		upd      = (elapsed > {{(TIME_W-DEB_W){1'b0}}, debounce_ms})
			&& (sample != cur.stable_vector);
		pressed  = upd ? (sample & ~cur.stable_vector) : '0;
		released = upd ? (cur.stable_vector & ~sample) : '0;

		if (upd) begin
			if ((pressed != '0) && (cur.stable_vector == '0))
				nxt.press_start_time = smp.now_ms;
			if ((released != '0) && (sample == '0))
				nxt.press_finish_time = smp.now_ms;
			nxt.stable_vector = sample;
		end

		res.stable_buttons = nxt.stable_vector;
		res.pressed_mask   = pressed;
		res.released_mask  = released;
		res.any_pressed    = |pressed;
		res.any_released   = |released;
		if (nxt.stable_vector != '0)
			res.held_ms = smp.now_ms - nxt.press_start_time;
		else
			res.held_ms = nxt.press_finish_time - nxt.press_start_time;
	end

endmodule

// ===== sv/button_vector_debounce_events_core.sv =====
// ----------------------------------------------------------------------------
// button_vector_debounce_events_core
// Debounces an 8-bit button vector and reports press/release events.
// ----------------------------------------------------------------------------
// Input channel: one request per sample (raw_buttons, read_failed, now_ms),
// taken when in_valid is high and in_stall is low. A failed read counts as
// all buttons released.
// Output channel: one request per sample with the debounced vector, the
// pressed/released masks, any-flags and held time, taken when out_valid is
// high and out_stall is low.
// Accepted requests go to the input register, results to the output register.
// Throughput: one request per cycle without receiver stalls; the state update
// (compare, 32-bit subtract, compare against debounce_ms) is combinational.
// The input register and the output register part the two sides; while the
// receiver stalls, one sample waits in the input register and in_stall rises.
// Reset: stable and raw vectors and all timestamps clear to zero,
// debounce_ms returns to 5, both channels go empty. The user must write
// debounce_ms (cfg_wr_en/cfg_wr_data) only while idle; the core does not check.
// ----------------------------------------------------------------------------
module button_vector_debounce_events_core
	import bvde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [DEB_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [VEC_W-1:0]  raw_buttons,
	input  logic              read_failed,
	input  logic [TIME_W-1:0] now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VEC_W-1:0]  stable_buttons,
	output logic [VEC_W-1:0]  pressed_mask,
	output logic [VEC_W-1:0]  released_mask,
	output logic              any_pressed,
	output logic              any_released,
	output logic [TIME_W-1:0] held_ms
);

	logic [DEB_W-1:0] debounce_q;
	logic             valid_s1;
	bvde_sample_t     smp_s1;
	bvde_state_t      state_q;
	bvde_state_t      state_nxt;
	bvde_result_t     res_nxt;
	bvde_result_t     res_s2;
	logic             valid_s2;
	logic             advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			debounce_q <= DEBOUNCE_RESET;
		else if (cfg_wr_en)
			debounce_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			smp_s1 <= '{raw_buttons: raw_buttons, read_failed: read_failed, now_ms: now_ms};
	end

	bvde_eval u_eval (
		.smp         (smp_s1),
		.debounce_ms (debounce_q),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (advance)
			state_q <= state_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nxt;
	end

	assign out_valid      = valid_s2;
	assign stable_buttons = res_s2.stable_buttons;
	assign pressed_mask   = res_s2.pressed_mask;
	assign released_mask  = res_s2.released_mask;
	assign any_pressed    = res_s2.any_pressed;
	assign any_released   = res_s2.any_released;
	assign held_ms        = res_s2.held_ms;

`ifndef ASSERT_OFF
	a_press_in_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((stable_buttons & pressed_mask) == pressed_mask))
		else $error("pressed button not in stable vector");

	a_release_not_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((stable_buttons & released_mask) == '0))
		else $error("released button still in stable vector");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a full pipe");

	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced sample produced no result");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("debounce state changed without a sample");
`endif

endmodule

// ===== tb/button_vector_debounce_events_core_tb.sv =====
// ----------------------------------------------------------------------------
// button_vector_debounce_events_core_tb
// Self-checking bench for the button debounce core. A behavioral model of
// the debounce state runs beside the core. Each accepted sample request
// queues one predicted result, and every result the core delivers is checked
// field by field against the oldest prediction. Directed samples cover the
// strict settle threshold, failed reads, full and partial press/release and
// timestamp wrap. Random phases then run across several settle times with
// bouncing vectors and random idling on both channels.
// ----------------------------------------------------------------------------
module button_vector_debounce_events_core_tb;
	import bvde_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [DEB_W-1:0]  cfg_wr_data;
	logic              in_valid;
	logic              in_stall;
	logic [VEC_W-1:0]  raw_buttons;
	logic              read_failed;
	logic [TIME_W-1:0] now_ms;
	logic              out_valid;
	logic              out_stall;
	logic [VEC_W-1:0]  stable_buttons;
	logic [VEC_W-1:0]  pressed_mask;
	logic [VEC_W-1:0]  released_mask;
	logic              any_pressed;
	logic              any_released;
	logic [TIME_W-1:0] held_ms;

	button_vector_debounce_events_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.raw_buttons    (raw_buttons),
		.read_failed    (read_failed),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.stable_buttons (stable_buttons),
		.pressed_mask   (pressed_mask),
		.released_mask  (released_mask),
		.any_pressed    (any_pressed),
		.any_released   (any_released),
		.held_ms        (held_ms)
	);

	// model state
	logic [DEB_W-1:0]  mdl_settle_ms;
	logic [VEC_W-1:0]  mdl_stable;
	logic [VEC_W-1:0]  mdl_last_raw;
	logic [TIME_W-1:0] mdl_change_t;
	logic [TIME_W-1:0] mdl_start_t;
	logic [TIME_W-1:0] mdl_finish_t;

	bvde_result_t      pending_results[$];
	int                errors;
	bit                quiet;
	int                stall_left;
	bit                stall_now;
	int                stall_roll;
	logic [TIME_W-1:0] clock_ms;
	logic [VEC_W-1:0]  held_target;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[button_vector_debounce_events_core] ERROR");
		$finish;
	end

	function automatic bvde_result_t predict_debounce(input logic [VEC_W-1:0] raw,
			input logic failed, input logic [TIME_W-1:0] t);
		bvde_result_t      res;
		logic [VEC_W-1:0]  smp;
		logic [VEC_W-1:0]  pr;
		logic [VEC_W-1:0]  rl;
		logic [TIME_W-1:0] since;
		smp = failed ? '0 : raw;
		smp = smp & BTN_MASK;
		pr = '0;
		rl = '0;
		if (smp != mdl_last_raw) begin
			mdl_change_t = t;
			mdl_last_raw = smp;
		end
		since = t - mdl_change_t;
		if (since > TIME_W'(mdl_settle_ms) && smp != mdl_stable) begin
			pr = smp & ~mdl_stable;
			rl = mdl_stable & ~smp;
			if (pr != '0 && mdl_stable == '0)
				mdl_start_t = t;
			if (rl != '0 && smp == '0)
				mdl_finish_t = t;
			mdl_stable = smp;
		end
		res.stable_buttons = mdl_stable;
		res.pressed_mask   = pr;
		res.released_mask  = rl;
		res.any_pressed    = (pr != '0);
		res.any_released   = (rl != '0);
		res.held_ms        = (mdl_stable != '0) ? (t - mdl_start_t) : (mdl_finish_t - mdl_start_t);
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_sample(input logic [VEC_W-1:0] raw, input logic failed,
			input logic [TIME_W-1:0] t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid    <= 1'b0;
			raw_buttons <= $urandom;
			read_failed <= $urandom;
			now_ms      <= $urandom;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		raw_buttons <= raw;
		read_failed <= failed;
		now_ms      <= t;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(predict_debounce(raw, failed, t));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_debounce(input logic [DEB_W-1:0] v);
		drain_results();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		mdl_settle_ms = v;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (quiet) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_roll = $urandom_range(0, 99);
				if (stall_roll < 50) begin
					stall_now  = 1'b0;
					stall_left = $urandom_range(1, 8);
				end else if (stall_roll < 90) begin
					stall_now  = 1'b1;
					stall_left = $urandom_range(1, 3);
				end else begin
					stall_now  = 1'b1;
					stall_left = $urandom_range(10, 40);
				end
			end
			stall_left = stall_left - 1;
			out_stall <= stall_now;
		end
	end

	always @(posedge clk) begin
		bvde_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request pending, actual stable %h held %h",
					$time, stable_buttons, held_ms);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("stable_buttons", want.stable_buttons, stable_buttons);
				check_field("pressed_mask", want.pressed_mask, pressed_mask);
				check_field("released_mask", want.released_mask, released_mask);
				check_field("any_pressed", want.any_pressed, any_pressed);
				check_field("any_released", want.any_released, any_released);
				check_field("held_ms", want.held_ms, held_ms);
			end
		end
	end

	// reset value of the settle time, strict compare, failed read, masks
	task automatic test_reset_threshold();
		send_sample(8'h01, 1'b0, 32'd100);
		send_sample(8'h01, 1'b0, 32'd105);
		send_sample(8'h01, 1'b0, 32'd106);
		send_sample(8'h01, 1'b0, 32'd110);
		send_sample(8'hFF, 1'b1, 32'd120);
		send_sample(8'h00, 1'b0, 32'd126);
		send_sample(8'hFF, 1'b0, 32'd200);
		send_sample(8'hFF, 1'b0, 32'd206);
		send_sample(8'h55, 1'b0, 32'd300);
		send_sample(8'h55, 1'b0, 32'd306);
		send_sample(8'hAA, 1'b0, 32'd400);
		send_sample(8'hAA, 1'b0, 32'd406);
		send_sample(8'h00, 1'b0, 32'd500);
		send_sample(8'h00, 1'b0, 32'd505);
		send_sample(8'h00, 1'b0, 32'd506);
		send_sample(8'h10, 1'b0, 32'd600);
		send_sample(8'h00, 1'b0, 32'd603);
		send_sample(8'h10, 1'b0, 32'd606);
		send_sample(8'h10, 1'b0, 32'd611);
		send_sample(8'h10, 1'b0, 32'd612);
	endtask

	// timestamps wrapping through zero and stepping backward
	task automatic test_time_wrap();
		send_sample(8'h80, 1'b0, 32'hFFFF_FFFC);
		send_sample(8'h80, 1'b0, 32'hFFFF_FFFF);
		send_sample(8'h80, 1'b0, 32'h0000_0002);
		send_sample(8'h80, 1'b0, 32'h0000_0064);
		send_sample(8'h00, 1'b0, 32'h0000_0032);
		send_sample(8'h00, 1'b0, 32'h0000_0028);
	endtask

	task automatic test_settle_extremes();
		set_debounce(16'd0);
		send_sample(8'h03, 1'b0, 32'd1000);
		send_sample(8'h03, 1'b0, 32'd1000);
		send_sample(8'h03, 1'b0, 32'd1001);
		set_debounce(16'hFFFF);
		send_sample(8'h0C, 1'b0, 32'd2000);
		send_sample(8'h0C, 1'b0, 32'd2000 + 32'd65535);
		send_sample(8'h0C, 1'b0, 32'd2000 + 32'd65536);
		clock_ms = 32'd2000 + 32'd65536;
		held_target = 8'h0C;
	endtask

	task automatic random_burst(input int n);
		int                hold;
		int                r;
		int                settle;
		logic [VEC_W-1:0]  v;
		logic              f;
		logic [TIME_W-1:0] step;
		hold = 0;
		settle = int'(mdl_settle_ms);
		for (int i = 0; i < n; i++) begin
			if (hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					held_target = '0;
				else if (r < 20)
					held_target = '1;
				else if (r < 55)
					held_target = held_target ^ (8'h01 << $urandom_range(0, 7));
				else
					held_target = $urandom;
				hold = $urandom_range(1, 12);
			end
			hold--;
			v = held_target;
			f = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				v = $urandom;
			end else if (r < 12) begin
				v = $urandom;
				f = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 85)
				step = $urandom_range(0, settle / 3 + 2);
			else if (r < 95)
				step = settle + $urandom_range(0, 1);
			else if (r < 98)
				step = $urandom;
			else
				step = -$urandom_range(1, 100);
			clock_ms = clock_ms + step;
			send_sample(v, f, clock_ms);
		end
	endtask

	task automatic test_random_settings();
		logic [DEB_W-1:0] settings[7];
		settings = '{16'd1, 16'd5, 16'd20, 16'd300, 16'd0, 16'hFFFF, 16'd0};
		settings[6] = $urandom_range(0, 65535);
		foreach (settings[k]) begin
			set_debounce(settings[k]);
			random_burst(245);
		end
	endtask

	// back-to-back requests with no stall on either side
	task automatic test_full_rate();
		drain_results();
		quiet = 1'b1;
		set_debounce(16'd3);
		random_burst(100);
		drain_results();
		quiet = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		raw_buttons = '0;
		read_failed = 1'b0;
		now_ms      = '0;
		out_stall   = 1'b0;
		errors      = 0;
		quiet       = 1'b0;
		stall_left  = 0;
		stall_now   = 1'b0;
		clock_ms    = '0;
		held_target = '0;
		mdl_settle_ms = DEBOUNCE_RESET;
		mdl_stable    = '0;
		mdl_last_raw  = '0;
		mdl_change_t  = '0;
		mdl_start_t   = '0;
		mdl_finish_t  = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_threshold();
		test_time_wrap();
		test_settle_extremes();
		test_random_settings();
		test_full_rate();

		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("[button_vector_debounce_events_core] OK");
		else
			$display("[button_vector_debounce_events_core] ERROR");
		$finish;
	end

endmodule
